// ----- hw/rtl/gwwa_pkg.sv -----
// gwwa_pkg: shared types and constants for the weighted window average block.
// Used by the channel interfaces, the divider and the top level; no dependencies.
`timescale 1ns / 1ps

package gwwa_pkg;

   // Field widths of the transactions and registers
   localparam int SAMPLE_W   = 32;
   localparam int WEIGHT_W   = 17;
   localparam int LEN_W      = 7;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // Fixed-point constants and sentinels
   localparam logic [WEIGHT_W-1:0] ONE_Q16        = 17'h10000;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 17'd57344;
   localparam logic [LEN_W-1:0]    WINDOW_LEN_RST = 7'd64;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // Operation codes of the request transaction
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT        = 1'b0,
      CSR_WINDOW_LENGTH = 1'b1
   } csr_reg_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- hw/rtl/gwwa_if.sv -----
// gwwa_if: valid/ready channel interfaces for requests and responses.
// Depends on gwwa_pkg for field widths.
`timescale 1ns / 1ps

interface gwwa_req_if import gwwa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, op, sample, input ready);
   modport sink   (input valid, op, sample, output ready);
endinterface

interface gwwa_rsp_if import gwwa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] average;
   logic [LEN_W-1:0]           entries;
   logic signed [SAMPLE_W-1:0] minimum;
   logic signed [SAMPLE_W-1:0] maximum;

   modport source (output valid, average, entries, minimum, maximum, input ready);
   modport sink   (input valid, average, entries, minimum, maximum, output ready);
endinterface

// ----- hw/rtl/geometric_weighted_window_average.sv -----
// Weighted sliding-window average over signed Q16.16 samples. Each request
// either pushes a sample (dropping the oldest once the window is full) or
// clears the window, and yields one response: the entry count, the window
// minimum and maximum (0x7FFFFFFF / 0x80000000 when empty) and the mean with
// the newest sample weighted 1.0 and each older one by one more factor of the
// Q1.16 weight (truncated), quotient truncated toward zero, 0 when empty.
// Samples live in a WINDOW-entry single-port-read RAM that is walked newest
// first, one entry a cycle, then a bit-serial divider runs NUM_W = 49 +
// clog2(WINDOW+1) steps. A push walks every stored entry, drains the pipeline,
// divides and responds; a clear responds without walking or dividing. Writing
// window_length empties the window; the RAM needs no clearing after reset.
// Depends on gwwa_pkg, gwwa_if, gwwa_ram and gwwa_div.
`timescale 1ns / 1ps

module geometric_weighted_window_average import gwwa_pkg::*; #(
   parameter int WINDOW = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   gwwa_req_if.sink              req_chan,
   gwwa_rsp_if.source            rsp_chan
);

   localparam int AW      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int PROD_W  = SAMPLE_W + WEIGHT_W + 1;
   localparam int NUM_W   = SAMPLE_W + WEIGHT_W + CNT_W;
   localparam int DEN_W   = WEIGHT_W + CNT_W;
   localparam int LEN_RST = (WINDOW < 64) ? WINDOW : 64;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_DIV,
      S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        wp_ff, wp_in;
   logic [AW-1:0]        rd_ff, rd_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [WEIGHT_W-1:0]  wq_ff, wq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [LEN_W-1:0]     rsp_entries_ff, rsp_entries_in;
   logic signed [SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff, rsp_max_in;

   logic                 iss_ff, iss_in;
   logic                 a_vld_ff;
   logic                 init_acc;
   logic                 div_start;
   div_stat_type         div_stat;
   logic signed [SAMPLE_W-1:0] div_quot;

   logic                 ram_we;
   logic                 ram_re;
   logic [SAMPLE_W-1:0]  ram_rdata;

   logic [AW:0]          wp_inc;
   logic [AW-1:0]        wp_next;
   logic [AW-1:0]        rd_next;
   logic [CNT_W-1:0]     cnt_push;
   logic [LEN_W-1:0]     csr_len;
   logic [CNT_W-1:0]     csr_len_eff;

   logic [WEIGHT_W-1:0]         w_ff;
   logic [2*WEIGHT_W-1:0]       w_prod;
   logic signed [PROD_W-1:0]    prod_full;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]            den_ff;
   logic signed [SAMPLE_W-1:0]  lo_ff;
   logic signed [SAMPLE_W-1:0]  hi_ff;
   logic signed [SAMPLE_W-1:0]  rd_sample;

   // Circular pointer arithmetic over the effective window length
   always_comb begin
      wp_inc   = {1'b0, wp_ff} + 1'b1;
      wp_next  = (32'(wp_inc) == 32'(len_ff)) ? '0 : wp_inc[AW-1:0];
      rd_next  = (rd_ff == '0) ? AW'(len_ff - 1'b1) : (rd_ff - 1'b1);
      cnt_push = (cnt_ff < len_ff) ? (cnt_ff + 1'b1) : cnt_ff;
   end

   // Saturate a window_length write to 1..WINDOW
   always_comb begin
      csr_len = csr_wdata[LEN_W-1:0];
      if (csr_len == '0) begin
         csr_len_eff = CNT_W'(1);
      end else if (32'(csr_len) > 32'(WINDOW)) begin
         csr_len_eff = CNT_W'(WINDOW);
      end else begin
         csr_len_eff = CNT_W'(csr_len);
      end
   end

   // Sequencer: on a push write, walk newest to oldest, drain, divide, respond; a clear responds directly
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      rd_in          = rd_ff;
      cnt_in         = cnt_ff;
      left_in        = left_ff;
      len_in         = len_ff;
      wq_in          = wq_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_entries_in = rsp_entries_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_max_in     = rsp_max_ff;
      iss_in         = 1'b0;
      init_acc       = 1'b0;
      div_start      = 1'b0;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               init_acc = 1'b1;
               if (req_chan.op == OP_CLEAR) begin
                  wp_in    = '0;
                  cnt_in   = '0;
                  state_in = S_OUT;
               end else begin
                  ram_we   = 1'b1;
                  rd_in    = wp_ff;
                  wp_in    = wp_next;
                  cnt_in   = cnt_push;
                  left_in  = cnt_push;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            ram_re  = 1'b1;
            iss_in  = 1'b1;
            rd_in   = rd_next;
            left_in = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!iss_ff && !a_vld_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_avg_in     = (cnt_ff == '0) ? '0 : div_quot;
               rsp_entries_in = LEN_W'(cnt_ff);
               rsp_min_in     = lo_ff;
               rsp_max_in     = hi_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes arrive only while idle; the user must keep to this, the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_WEIGHT: begin
               wq_in = (csr_wdata[WEIGHT_W-1:0] > ONE_Q16) ? ONE_Q16
                                                            : csr_wdata[WEIGHT_W-1:0];
            end
            CSR_WINDOW_LENGTH: begin
               len_in = csr_len_eff;
               wp_in  = '0;
               cnt_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wp_ff          <= '0;
         cnt_ff         <= '0;
         len_ff         <= CNT_W'(LEN_RST);
         wq_ff          <= WEIGHT_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         wp_ff          <= wp_in;
         cnt_ff         <= cnt_in;
         len_ff         <= len_in;
         wq_ff          <= wq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rd_ff          <= rd_in;
      left_ff        <= left_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_entries_ff <= rsp_entries_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_max_ff     <= rsp_max_in;
   end

   // Sample store; a push writes an entry in the cycle before the walk reads it
   gwwa_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (req_chan.sample),
      .re    (ram_re),
      .raddr (rd_ff),
      .rdata (ram_rdata)
   );

   // Track which pipeline stages hold a live sample
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff   <= 1'b0;
         a_vld_ff <= 1'b0;
      end else begin
         iss_ff   <= iss_in;
         a_vld_ff <= iss_ff;
      end
   end

   // Stage A: weight the sample, update extremes and weight sum, decay weight
   // Stage B: add the weighted sample into the numerator
   assign rd_sample = $signed(ram_rdata);
   assign prod_full = rd_sample * $signed({1'b0, w_ff});
   assign w_prod    = w_ff * wq_ff;

   always_ff @(posedge clock) begin
      if (init_acc) begin
         w_ff   <= ONE_Q16;
         num_ff <= '0;
         den_ff <= '0;
         lo_ff  <= SAMPLE_MAX;
         hi_ff  <= SAMPLE_MIN;
      end else begin
         if (iss_ff) begin
            prod_ff <= prod_full;
            den_ff  <= den_ff + DEN_W'(w_ff);
            w_ff    <= w_prod[WEIGHT_W+FRAC_W-1:FRAC_W];
            if (rd_sample < lo_ff) begin
               lo_ff <= rd_sample;
            end
            if (rd_sample > hi_ff) begin
               hi_ff <= rd_sample;
            end
         end
         if (a_vld_ff) begin
            num_ff <= num_ff + NUM_W'(prod_ff);
         end
      end
   end

   gwwa_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // Drive the channel ports
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.average = rsp_avg_ff;
   assign rsp_chan.entries = rsp_entries_ff;
   assign rsp_chan.minimum = rsp_min_ff;
   assign rsp_chan.maximum = rsp_max_ff;

   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= len_ff && 32'(wp_ff) < 32'(len_ff))
      else $error("entry count or write pointer outside the window");

   a_div_after_drain: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !iss_ff && !a_vld_ff && !div_stat.busy)
      else $error("divider started with samples still in flight");

   a_write_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == S_IDLE && req_chan.valid && req_chan.op == OP_PUSH)
      else $error("store written outside a push transaction");

   a_ordered_extremes: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_entries_ff != '0 |-> rsp_min_ff <= rsp_max_ff)
      else $error("response minimum above maximum");

endmodule

// ----- hw/rtl/gwwa_ram.sv -----
// gwwa_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gwwa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/gwwa_div.sv -----
// gwwa_div: radix-2 restoring divider, one quotient bit per cycle, truncating
// toward zero. Signed dividend, positive divisor. Depends on gwwa_pkg.
`timescale 1ns / 1ps

module gwwa_div import gwwa_pkg::*; #(
   parameter int NUM_W = 55,
   parameter int DEN_W = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic signed [NUM_W-1:0]    num,
   input  logic [DEN_W-1:0]           den,
   output div_stat_type               stat,
   output logic signed [SAMPLE_W-1:0] quot
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;
   logic              fits;
   logic [SAMPLE_W-1:0] q_mag;

   // One restoring step: bring down the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, dvd_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(NUM_W);
         dvd_in  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[NUM_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         dvd_in  = {dvd_ff[NUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // Apply the sign to the quotient magnitude
   assign q_mag     = dvd_ff[SAMPLE_W-1:0];
   assign quot      = neg_ff ? $signed(-q_mag) : $signed(q_mag);
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   a_step_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != '0)
      else $error("divider busy with no steps left");

endmodule
